FILE: hdl/http_request_header_tokenizer_macros.svh
// Assertion macros used by the tokenizer top level.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define HRT_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on the block clock, off during reset.
`define HRT_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tokenizer assertion failed");

`endif

FILE: hdl/hrt_pkg.sv
// Shared types, codes and helper functions of the HTTP request tokenizer.
`default_nettype none

package hrt_pkg;

   // Result kinds
   localparam logic [3:0] KindVerb        = 4'd0;
   localparam logic [3:0] KindUri         = 4'd1;
   localparam logic [3:0] KindReqOk       = 4'd2;
   localparam logic [3:0] KindName        = 4'd3;
   localparam logic [3:0] KindValue       = 4'd4;
   localparam logic [3:0] KindHeaderEnd   = 4'd5;
   localparam logic [3:0] KindHeadersDone = 4'd6;
   localparam logic [3:0] KindBody        = 4'd7;
   localparam logic [3:0] KindBodyDone    = 4'd8;
   localparam logic [3:0] KindError       = 4'd9;

   // Error codes
   localparam logic ErrTooLong = 1'b0;  // 431
   localparam logic ErrBadReq  = 1'b1;  // 400

   // Method codes
   localparam logic VerbGet  = 1'b0;
   localparam logic VerbPost = 1'b1;

   // Characters
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChG     = 8'h47;
   localparam logic [7:0] ChE     = 8'h45;
   localparam logic [7:0] ChT     = 8'h54;
   localparam logic [7:0] ChP     = 8'h50;
   localparam logic [7:0] ChO     = 8'h4F;
   localparam logic [7:0] ChS     = 8'h53;

   // Method match progress
   localparam logic [2:0] VmNone = 3'd0;
   localparam logic [2:0] VmG    = 3'd1;
   localparam logic [2:0] VmGe   = 3'd2;
   localparam logic [2:0] VmGet  = 3'd3;
   localparam logic [2:0] VmP    = 3'd4;
   localparam logic [2:0] VmPo   = 3'd5;
   localparam logic [2:0] VmPos  = 3'd6;
   localparam logic [2:0] VmPost = 3'd7;
   localparam logic [3:0] VmMiss = 4'b1000;

   // Configuration registers
   localparam int         MaxLineBits  = 13;
   localparam int         BodyLenBits  = 24;
   localparam logic       CsrMaxLine   = 1'b0;
   localparam logic       CsrBodyLen   = 1'b1;
   localparam logic [MaxLineBits-1:0] MaxLineReset = 13'd1024;
   localparam logic [BodyLenBits-1:0] BodyLenReset = 24'd0;

   // Result queue
   localparam int RspDepth     = 4;
   localparam int RspPtrBits   = 2;
   localparam int RspLevelBits = 3;
   localparam logic [RspLevelBits-1:0] RspTakeMax = 3'd2;

   typedef enum logic [3:0] {
      PhReq  = 4'b0001,
      PhHdr  = 4'b0010,
      PhBody = 4'b0100,
      PhEnd  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data;
      logic       verb_code;
      logic       error_code;
      logic       last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type item1;
      result_type item0;
   } res_pair_type;

   typedef struct packed {
      logic [RspLevelBits-1:0] level;
      logic                    can_take;
   } fifo_status_type;

   // Append one result to the pair; count never passes two.
   function automatic res_pair_type push_result(res_pair_type p, logic [3:0] kind,
                                                logic [7:0] data, logic verb, logic err);
      result_type   r;
      res_pair_type q;
      r.kind       = kind;
      r.data       = data;
      r.verb_code  = verb;
      r.error_code = err;
      r.last       = 1'b0;
      q = p;
      if (p.count == 2'd0) begin
         q.item0 = r;
      end else begin
         q.item1 = r;
      end
      q.count = p.count + 2'd1;
      return q;
   endfunction

   // Advance the method match; bit 3 set means the byte cannot continue it.
   function automatic logic [3:0] verb_next(logic [2:0] m, logic [7:0] b);
      logic [3:0] n;
      n = VmMiss;
      case (m)
         VmNone: begin
            if (b == ChG) n = {1'b0, VmG};
            else if (b == ChP) n = {1'b0, VmP};
         end
         VmG:   if (b == ChE) n = {1'b0, VmGe};
         VmGe:  if (b == ChT) n = {1'b0, VmGet};
         VmP:   if (b == ChO) n = {1'b0, VmPo};
         VmPo:  if (b == ChS) n = {1'b0, VmPos};
         VmPos: if (b == ChT) n = {1'b0, VmPost};
         default: n = VmMiss;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/http_request_header_tokenizer.sv
// Top level of the HTTP request header tokenizer: config registers, parser, result queue.
//
//   Channel  Dir  Transaction                Payload
//   req_     in   one request byte           tdata[7:0] byte
//   rsp_     out  one token                  tuser kind, tdata value, tlast end of byte
//   csr_     in   one register write         index, data
//
// Accepts one byte per cycle while the result queue has room. A byte waits in the
// input register until the queue can take its results, which are then written into
// the four-entry result queue, and tokens leave on rsp_ from the queue head. A byte
// gives zero, one or two tokens and each token takes one rsp_ transaction, so the
// output port sets the rate when bytes give two tokens. Reset is synchronous: parser
// back at the request line, queue empty, max_line_length 1024, body_length 0.
// req_tready drops while the queue holds three or more tokens and the input register
// is full.
`default_nettype none
`include "http_request_header_tokenizer_macros.svh"

module http_request_header_tokenizer #(
   parameter int LINE_COUNT_BITS = 13
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request byte stream
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [7:0]                        req_tdata,   // [7:0] in_byte
   // token stream
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [15:0]                       rsp_tdata,   // [7:0] data, [8] verb_code,
                                                               // [9] error_code, [15:10] zero
   output      logic [3:0]                        rsp_tuser,   // [3:0] kind
   output      logic                              rsp_tlast,   // last token of its byte
   // register writes
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [hrt_pkg::BodyLenBits-1:0]   csr_data
);

   logic [hrt_pkg::MaxLineBits-1:0]  max_line_ff, max_line_in;
   logic [hrt_pkg::BodyLenBits-1:0]  body_len_ff, body_len_in;
   hrt_pkg::res_pair_type            push;
   hrt_pkg::result_type              head;
   hrt_pkg::fifo_status_type         status;
   logic                             pop;
   logic                             rsp_final;

   // Writes are always taken; the user must write the block only while idle, and the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      max_line_in = max_line_ff;
      body_len_in = body_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            hrt_pkg::CsrMaxLine: max_line_in = csr_data[hrt_pkg::MaxLineBits-1:0];
            hrt_pkg::CsrBodyLen: body_len_in = csr_data;
            default: begin
               max_line_in = max_line_ff;
               body_len_in = body_len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff <= hrt_pkg::MaxLineReset;
         body_len_ff <= hrt_pkg::BodyLenReset;
      end else begin
         max_line_ff <= max_line_in;
         body_len_ff <= body_len_in;
      end
   end

   // Parse one byte per cycle, while the result queue has room, into zero to two tokens.
   hrt_core #(
      .LINE_COUNT_BITS (LINE_COUNT_BITS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .in_byte         (req_tdata),
      .max_line_length (max_line_ff),
      .body_length     (body_len_ff),
      .can_take        (status.can_take),
      .push            (push)
   );

   // Hold tokens until the consumer takes them.
   hrt_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   assign rsp_tvalid = (status.level != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {6'd0, head.error_code, head.verb_code, head.data};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // Error and body-done end the stream.
   assign rsp_final  = (rsp_tuser == hrt_pkg::KindError) ||
                       (rsp_tuser == hrt_pkg::KindBodyDone);

   // Queue never overfills.
   `HRT_ASSERT_IMPL(a_queue_bound, 1'b1, status.level <= hrt_pkg::RspLevelBits'(hrt_pkg::RspDepth))
   // Error and body-done close a byte's tokens.
   `HRT_ASSERT_IMPL(a_final_is_last, rsp_tvalid && rsp_final, rsp_tlast)
   // Nothing follows once the stream has ended or failed.
   `HRT_ASSERT_NEXT(a_quiet_after_end, pop && rsp_final, !rsp_tvalid)

endmodule

`default_nettype wire

FILE: hdl/hrt_core.sv
// Input register, parser state and one-pass step logic of the tokenizer.
`default_nettype none

module hrt_core #(
   parameter int LINE_COUNT_BITS = 13
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output      logic                              in_ready,
   input  wire logic [7:0]                        in_byte,
   input  wire logic [hrt_pkg::MaxLineBits-1:0]   max_line_length,
   input  wire logic [hrt_pkg::BodyLenBits-1:0]   body_length,
   input  wire logic                              can_take,
   output      hrt_pkg::res_pair_type             push
);

   localparam int LimW = (LINE_COUNT_BITS > hrt_pkg::MaxLineBits) ?
                         LINE_COUNT_BITS : hrt_pkg::MaxLineBits;
   localparam logic [LimW-1:0] LineCap = LimW'((64'd1 << LINE_COUNT_BITS) - 64'd1);

   typedef struct packed {
      hrt_pkg::phase_type                phase;
      logic [LINE_COUNT_BITS-1:0]        line_count;
      logic [1:0]                        space_count;
      logic [2:0]                        verb_match;
      logic                              uri_nonempty;
      logic                              colon_seen;
      logic                              value_started;
      logic                              cr_pending;
      logic [hrt_pkg::BodyLenBits-1:0]   body_left;
   } pstate_type;

   typedef struct packed {
      pstate_type            st;
      hrt_pkg::res_pair_type pr;
   } step_type;

   // One content byte of a request or header line.
   function automatic step_type content_step(step_type s, logic [7:0] b,
                                             logic [LINE_COUNT_BITS-1:0] lim);
      step_type   r;
      logic [3:0] vn;
      r  = s;
      vn = hrt_pkg::verb_next(r.st.verb_match, b);
      if (r.st.line_count >= lim) begin
         r.st.phase = hrt_pkg::PhEnd;
         r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindError, 8'd0, 1'b0,
                                     hrt_pkg::ErrTooLong);
      end else begin
         r.st.line_count = r.st.line_count + LINE_COUNT_BITS'(1);
         if (r.st.phase == hrt_pkg::PhReq) begin
            if (r.st.space_count == 2'd0) begin
               if (b == hrt_pkg::ChSpace) begin
                  if (r.st.verb_match != hrt_pkg::VmGet &&
                      r.st.verb_match != hrt_pkg::VmPost) begin
                     r.st.phase = hrt_pkg::PhEnd;
                     r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindError, 8'd0, 1'b0,
                                                 hrt_pkg::ErrBadReq);
                  end else begin
                     r.st.space_count = 2'd1;
                     r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindVerb, 8'd0,
                                                 r.st.verb_match == hrt_pkg::VmPost, 1'b0);
                  end
               end else if (vn[3]) begin
                  r.st.verb_match = hrt_pkg::VmNone;
                  r.st.phase = hrt_pkg::PhEnd;
                  r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindError, 8'd0, 1'b0,
                                              hrt_pkg::ErrBadReq);
               end else begin
                  r.st.verb_match = vn[2:0];
               end
            end else if (r.st.space_count == 2'd1) begin
               if (b == hrt_pkg::ChSpace) begin
                  if (!r.st.uri_nonempty) begin
                     r.st.phase = hrt_pkg::PhEnd;
                     r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindError, 8'd0, 1'b0,
                                                 hrt_pkg::ErrBadReq);
                  end else begin
                     r.st.space_count = 2'd2;
                  end
               end else begin
                  r.st.uri_nonempty = 1'b1;
                  r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindUri, b, 1'b0, 1'b0);
               end
            end
         end else begin
            if (!r.st.colon_seen) begin
               if (b == hrt_pkg::ChColon) begin
                  r.st.colon_seen = 1'b1;
               end else begin
                  r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindName, b, 1'b0, 1'b0);
               end
            end else if (r.st.value_started || b != hrt_pkg::ChSpace) begin
               r.st.value_started = 1'b1;
               r.pr = hrt_pkg::push_result(r.pr, hrt_pkg::KindValue, b, 1'b0, 1'b0);
            end
         end
      end
      return r;
   endfunction

   pstate_type                 state_ff, state_in;
   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic                       consume;
   logic [LimW-1:0]            mll_ext;
   logic [LINE_COUNT_BITS-1:0] lim;
   step_type                   stp;

   assign consume  = in_valid_ff & can_take;
   assign in_ready = ~in_valid_ff | consume;
   assign mll_ext  = LimW'(max_line_length);
   assign lim      = (mll_ext > LineCap) ? LineCap[LINE_COUNT_BITS-1:0] :
                                           mll_ext[LINE_COUNT_BITS-1:0];

   always_comb begin
      stp.st = state_ff;
      stp.pr = '0;
      case (state_ff.phase)
         hrt_pkg::PhBody: begin
            stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindBody, in_byte_ff,
                                          1'b0, 1'b0);
            if (stp.st.body_left != '0) begin
               stp.st.body_left = stp.st.body_left - hrt_pkg::BodyLenBits'(1);
            end
            if (stp.st.body_left == '0) begin
               stp.st.phase = hrt_pkg::PhEnd;
               stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindBodyDone, 8'd0,
                                             1'b0, 1'b0);
            end
         end
         hrt_pkg::PhReq, hrt_pkg::PhHdr: begin
            if (in_byte_ff == hrt_pkg::ChLf) begin
               stp.st.cr_pending    = 1'b0;
               stp.st.line_count    = '0;
               stp.st.colon_seen    = 1'b0;
               stp.st.value_started = 1'b0;
               if (state_ff.phase == hrt_pkg::PhReq) begin
                  if (state_ff.space_count != 2'd2) begin
                     stp.st.phase = hrt_pkg::PhEnd;
                     stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindError, 8'd0,
                                                   1'b0, hrt_pkg::ErrBadReq);
                  end else begin
                     stp.st.phase = hrt_pkg::PhHdr;
                     stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindReqOk, 8'd0,
                                 state_ff.verb_match == hrt_pkg::VmPost, 1'b0);
                  end
               end else if (state_ff.line_count != '0) begin
                  stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindHeaderEnd, 8'd0,
                                                1'b0, 1'b0);
               end else begin
                  // blank line: headers are over
                  stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindHeadersDone, 8'd0,
                                                1'b0, 1'b0);
                  if (body_length == '0) begin
                     stp.st.phase = hrt_pkg::PhEnd;
                     stp.pr = hrt_pkg::push_result(stp.pr, hrt_pkg::KindBodyDone, 8'd0,
                                                   1'b0, 1'b0);
                  end else begin
                     stp.st.body_left = body_length;
                     stp.st.phase     = hrt_pkg::PhBody;
                  end
               end
            end else begin
               // a held CR that is not followed by LF counts as content first
               if (stp.st.cr_pending) begin
                  stp.st.cr_pending = 1'b0;
                  stp = content_step(stp, hrt_pkg::ChCr, lim);
               end
               if (stp.st.phase != hrt_pkg::PhEnd) begin
                  if (in_byte_ff == hrt_pkg::ChCr) begin
                     stp.st.cr_pending = 1'b1;
                  end else begin
                     stp = content_step(stp, in_byte_ff, lim);
                  end
               end
            end
         end
         default: begin
            stp.st = state_ff;
         end
      endcase
      if (stp.pr.count == 2'd2) begin
         stp.pr.item1.last = 1'b1;
      end else if (stp.pr.count == 2'd1) begin
         stp.pr.item0.last = 1'b1;
      end
      state_in = consume ? stp.st : state_ff;
      push     = stp.pr;
      if (!consume) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= hrt_pkg::PhReq;
         state_ff.line_count    <= '0;
         state_ff.space_count   <= 2'd0;
         state_ff.verb_match    <= hrt_pkg::VmNone;
         state_ff.uri_nonempty  <= 1'b0;
         state_ff.colon_seen    <= 1'b0;
         state_ff.value_started <= 1'b0;
         state_ff.cr_pending    <= 1'b0;
         state_ff.body_left     <= '0;
         in_valid_ff            <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (in_valid && in_ready) begin
            in_valid_ff <= 1'b1;
         end else if (consume) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         in_byte_ff <= in_byte;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/hrt_rsp_fifo.sv
// Four-entry result queue that takes up to two results per cycle.
`default_nettype none

module hrt_rsp_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hrt_pkg::res_pair_type     push,
   input  wire logic                      pop,
   output      hrt_pkg::result_type       head,
   output      hrt_pkg::fifo_status_type  status
);

   hrt_pkg::result_type                    entry_ff [hrt_pkg::RspDepth];
   logic [hrt_pkg::RspPtrBits-1:0]         wr_ptr_ff, rd_ptr_ff;
   logic [hrt_pkg::RspPtrBits-1:0]         wr_next;
   logic [hrt_pkg::RspLevelBits-1:0]       level_ff, level_in;

   assign wr_next         = wr_ptr_ff + hrt_pkg::RspPtrBits'(1);
   assign level_in        = level_ff + hrt_pkg::RspLevelBits'(push.count) -
                            hrt_pkg::RspLevelBits'(pop);
   assign head            = entry_ff[rd_ptr_ff];
   assign status.level    = level_ff;
   assign status.can_take = (level_ff <= hrt_pkg::RspTakeMax);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push.count;
         rd_ptr_ff <= rd_ptr_ff + hrt_pkg::RspPtrBits'(pop);
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.item1;
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the HTTP request header tokenizer: request bytes in, tokens out.
//
// The block parses a single request per reset, and any error ends the parse for good.
// The run usually walks through one request from the request line to the end of the
// body. Now and then the request line is malformed; then the ignored input after the
// error is checked, reset is applied again and a well formed request follows. Each
// run draws one way to end the request: an overlong header line, a zero-length body,
// or a full body. The simulator seed decides which one, so regressions over many
// seeds cover all of them.
//
// A predictor in this file follows the parser byte by byte and queues the tokens
// each accepted byte must produce. A monitor pops one expectation per rsp_
// transaction and compares it field by field.

module testbench;

   localparam int LimitTime    = 4_000_000;  // time units
   localparam int LineBits     = 13;         // LINE_COUNT_BITS of the instance
   localparam int SettleCycles = 6;          // covers the byte-to-token path from input register to queue
   localparam int ReportCap    = 100;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [7:0]                      req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [15:0]                     rsp_tdata;
   logic [3:0]                      rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid;
   logic                            csr_ready;
   logic                            csr_index;
   logic [hrt_pkg::BodyLenBits-1:0] csr_data;

   // Predictor copy of the parser state and of the two registers
   hrt_pkg::phase_type              parse_phase;
   logic [LineBits-1:0]             line_len;
   logic [1:0]                      spaces_seen;
   logic [2:0]                      method_progress;
   logic                            uri_seen;
   logic                            colon_found;
   logic                            value_begun;
   logic                            cr_held;
   logic [hrt_pkg::BodyLenBits-1:0] body_remaining;
   logic [hrt_pkg::MaxLineBits-1:0] line_limit_cfg;
   logic [hrt_pkg::BodyLenBits-1:0] body_len_cfg;

   hrt_pkg::result_type    expected_tokens[$];   // tokens owed by the block, oldest first
   hrt_pkg::result_type    step_tokens[$];       // tokens of the byte being predicted
   hrt_pkg::result_type    token_due;

   int                     failure_count = 0;
   int                     bytes_sent    = 0;
   int                     hold_off_left = 0;    // long receiver stall, counted by the receiver
   bit                     quiet         = 1'b0; // no gaps on either side while set

   string                  token_chars =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ-0123456789";

   http_request_header_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(LimitTime);
      $display("*** FAILED ***");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_parse_model();
      parse_phase     = hrt_pkg::PhReq;
      line_len        = '0;
      spaces_seen     = 2'd0;
      method_progress = hrt_pkg::VmNone;
      uri_seen        = 1'b0;
      colon_found     = 1'b0;
      value_begun     = 1'b0;
      cr_held         = 1'b0;
      body_remaining  = '0;
      line_limit_cfg  = hrt_pkg::MaxLineReset;
      body_len_cfg    = hrt_pkg::BodyLenReset;
   endfunction

   function automatic void emit_token(logic [3:0] kind, logic [7:0] data, logic verb,
                                      logic err);
      hrt_pkg::result_type tok;
      tok.kind       = kind;
      tok.data       = data;
      tok.verb_code  = verb;
      tok.error_code = err;
      tok.last       = 1'b0;
      step_tokens.push_back(tok);
   endfunction

   // Any error parks the parser for good.
   function automatic void raise_error(logic code);
      parse_phase = hrt_pkg::PhEnd;
      emit_token(hrt_pkg::KindError, 8'd0, 1'b0, code);
   endfunction

   // Match progress after one more method letter; bit 3 flags a byte that fits neither method.
   function automatic logic [3:0] method_after(logic [2:0] m, logic [7:0] b);
      logic [7:0] want;
      if (m == hrt_pkg::VmNone) begin
         if (b == hrt_pkg::ChG) return {1'b0, hrt_pkg::VmG};
         if (b == hrt_pkg::ChP) return {1'b0, hrt_pkg::VmP};
         return hrt_pkg::VmMiss;
      end
      if (m == hrt_pkg::VmGet || m == hrt_pkg::VmPost) return hrt_pkg::VmMiss;
      // both spellings advance one step per matching letter
      case (m)
         hrt_pkg::VmG:  want = hrt_pkg::ChE;
         hrt_pkg::VmP:  want = hrt_pkg::ChO;
         hrt_pkg::VmPo: want = hrt_pkg::ChS;
         default:       want = hrt_pkg::ChT;
      endcase
      return (b == want) ? {1'b0, m + 3'd1} : hrt_pkg::VmMiss;
   endfunction

   // One counted byte of a line (anything but LF and a dropped CR).
   function automatic void content_byte(logic [7:0] b);
      int         cap;
      int         limit;
      logic [3:0] nxt;
      cap   = (1 << LineBits) - 1;
      limit = (int'(line_limit_cfg) < cap) ? int'(line_limit_cfg) : cap;
      if (int'(line_len) >= limit) begin
         raise_error(hrt_pkg::ErrTooLong);
         return;
      end
      line_len = line_len + LineBits'(1);

      if (parse_phase == hrt_pkg::PhReq) begin
         if (spaces_seen == 2'd0) begin
            if (b == hrt_pkg::ChSpace) begin
               if (method_progress != hrt_pkg::VmGet &&
                   method_progress != hrt_pkg::VmPost) begin
                  raise_error(hrt_pkg::ErrBadReq);
               end else begin
                  spaces_seen = 2'd1;
                  emit_token(hrt_pkg::KindVerb, 8'd0, method_progress == hrt_pkg::VmPost,
                             1'b0);
               end
               return;
            end
            nxt = method_after(method_progress, b);
            if (nxt[3]) begin
               method_progress = hrt_pkg::VmNone;
               raise_error(hrt_pkg::ErrBadReq);
            end else begin
               method_progress = nxt[2:0];
            end
         end else if (spaces_seen == 2'd1) begin
            if (b == hrt_pkg::ChSpace) begin
               if (!uri_seen) raise_error(hrt_pkg::ErrBadReq);
               else spaces_seen = 2'd2;
            end else begin
               uri_seen = 1'b1;
               emit_token(hrt_pkg::KindUri, b, 1'b0, 1'b0);
            end
         end
         return;
      end

      // header line: name up to the first colon, value after it minus leading spaces
      if (!colon_found) begin
         if (b == hrt_pkg::ChColon) colon_found = 1'b1;
         else emit_token(hrt_pkg::KindName, b, 1'b0, 1'b0);
      end else if (value_begun || b != hrt_pkg::ChSpace) begin
         value_begun = 1'b1;
         emit_token(hrt_pkg::KindValue, b, 1'b0, 1'b0);
      end
   endfunction

   function automatic void end_of_line();
      logic was_blank;
      was_blank   = (line_len == 0);
      line_len    = '0;
      colon_found = 1'b0;
      value_begun = 1'b0;
      if (parse_phase == hrt_pkg::PhReq) begin
         if (spaces_seen < 2'd2) begin
            raise_error(hrt_pkg::ErrBadReq);
         end else begin
            parse_phase = hrt_pkg::PhHdr;
            emit_token(hrt_pkg::KindReqOk, 8'd0, method_progress == hrt_pkg::VmPost, 1'b0);
         end
      end else if (!was_blank) begin
         emit_token(hrt_pkg::KindHeaderEnd, 8'd0, 1'b0, 1'b0);
      end else begin
         // blank line: body length is sampled here
         emit_token(hrt_pkg::KindHeadersDone, 8'd0, 1'b0, 1'b0);
         if (body_len_cfg == 0) begin
            parse_phase = hrt_pkg::PhEnd;
            emit_token(hrt_pkg::KindBodyDone, 8'd0, 1'b0, 1'b0);
         end else begin
            body_remaining = body_len_cfg;
            parse_phase    = hrt_pkg::PhBody;
         end
      end
   endfunction

   // Advance the predictor by one accepted byte and queue the tokens it owes.
   function automatic void tokenize_byte(logic [7:0] b);
      hrt_pkg::result_type tok;
      step_tokens.delete();
      if (parse_phase == hrt_pkg::PhBody) begin
         emit_token(hrt_pkg::KindBody, b, 1'b0, 1'b0);
         if (body_remaining > 0) body_remaining = body_remaining - 1'b1;
         if (body_remaining == 0) begin
            parse_phase = hrt_pkg::PhEnd;
            emit_token(hrt_pkg::KindBodyDone, 8'd0, 1'b0, 1'b0);
         end
      end else if (parse_phase != hrt_pkg::PhEnd) begin
         if (b == hrt_pkg::ChLf) begin
            cr_held = 1'b0;
            end_of_line();
         end else begin
            // a held CR not followed by LF counts as content, ahead of this byte
            if (cr_held) begin
               cr_held = 1'b0;
               content_byte(hrt_pkg::ChCr);
            end
            if (parse_phase != hrt_pkg::PhEnd) begin
               if (b == hrt_pkg::ChCr) cr_held = 1'b1;
               else content_byte(b);
            end
         end
      end
      foreach (step_tokens[i]) begin
         tok      = step_tokens[i];
         tok.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(tok);
      end
   endfunction

   // ---------------------------------------------------------------- result monitor

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         failure_count++;
         if (failure_count <= ReportCap)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endfunction

   // Pop the oldest expectation on every rsp_ transaction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            failure_count++;
            if (failure_count <= ReportCap)
               $error("token with nothing expected: kind %0d data %0d", rsp_tuser,
                      rsp_tdata[7:0]);
         end else begin
            token_due = expected_tokens.pop_front();
            check_field("kind", token_due.kind, rsp_tuser);
            check_field("data", token_due.data, rsp_tdata[7:0]);
            check_field("verb_code", token_due.verb_code, rsp_tdata[8]);
            check_field("error_code", token_due.error_code, rsp_tdata[9]);
            check_field("tdata_pad", 0, rsp_tdata[15:10]);
            check_field("last", token_due.last, rsp_tlast);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Mostly no gap, a few short ones, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver: random stalls, plus the long hold-off a test may request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 1) == 1) stall_left = pick_gap();
         end
      end
   end

   // Offer one byte, hold it until taken, then predict its tokens.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tokenize_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Send the first n letters of a method name.
   task automatic send_prefix(input string word, input int n);
      for (int i = 0; i < n; i++) send_byte(word[i]);
   endtask

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Any byte that does not end the line.
   function automatic logic [7:0] line_byte();
      logic [7:0] b;
      do b = random_byte(); while (b == hrt_pkg::ChLf);
      return b;
   endfunction

   function automatic logic [7:0] printable_byte();
      return 8'($urandom_range(33, 126));
   endfunction

   // Drop valid, let every owed token drain, then allow for bytes still in flight.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic idx,
                                 input logic [hrt_pkg::BodyLenBits-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == hrt_pkg::CsrMaxLine) line_limit_cfg = value[hrt_pkg::MaxLineBits-1:0];
      else body_len_cfg = value;
   endtask

   // Drain, pulse reset and start the predictor over.
   task automatic restart();
      wait_drained();
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      reset_parse_model();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_setup();
      // only the low 13 bits of the line limit are kept, so this is 1024
      write_register(hrt_pkg::CsrMaxLine, 24'hFFE400);
      // sampled only at the blank line, so any value is harmless here
      write_register(hrt_pkg::CsrBodyLen, 24'hFFFFFF);
   endtask

   // Request line: usually well formed, now and then one of the malformed forms.
   task automatic test_request_line(input bit allow_bad, output bit accepted);
      string      verb;
      int         p;
      logic [7:0] b;
      verb = ($urandom_range(0, 1) == 1) ? "POST" : "GET";
      if (!allow_bad || $urandom_range(0, 7) != 0) begin
         send_text(verb);
         send_text(" /");
         // extreme byte values, a colon, and a CR that is not followed by LF
         send_byte(8'h00);
         send_byte(8'hFF);
         send_text(":\rA");
         repeat ($urandom_range(0, 30)) begin
            do b = random_byte(); while (b == hrt_pkg::ChSpace || b == hrt_pkg::ChLf);
            send_byte(b);
         end
         send_text(" HTTP/1.1\r\n");
      end else begin
         case ($urandom_range(0, 4))
            0: begin
               // method letters that fit neither GET nor POST
               p = $urandom_range(0, verb.len());
               send_prefix(verb, p);
               do b = random_byte();
               while (b == hrt_pkg::ChSpace || b == hrt_pkg::ChLf || b == hrt_pkg::ChCr ||
                      (p < verb.len() && b == verb[p]) ||
                      (p == 0 && (b == hrt_pkg::ChG || b == hrt_pkg::ChP)));
               send_byte(b);
            end
            1: begin
               // space before the method is complete
               p = $urandom_range(0, verb.len() - 1);
               send_prefix(verb, p);
               send_byte(hrt_pkg::ChSpace);
            end
            2: begin
               // empty URI
               send_text(verb);
               send_text("  ");
            end
            3: begin
               // line ends before the second space, the empty line among them
               case ($urandom_range(0, 2))
                  0: send_text("\n");
                  1: send_text("\r\n");
                  default: begin
                     send_text(verb);
                     send_text(" /x\r\n");
                  end
               endcase
            end
            default: begin
               // request line longer than the limit
               write_register(hrt_pkg::CsrMaxLine, 24'd16);
               send_text(verb);
               send_text(" /");
               repeat (20) send_byte(printable_byte());
            end
         endcase
      end
      accepted = (parse_phase == hrt_pkg::PhHdr);
   endtask

   task automatic test_header_forms();
      send_text("Host: a\r\n");      // leading space of the value skipped
      send_text("X:   v w\n");       // inner spaces kept, bare LF ends the line
      send_text("Flag\r\n");         // name only
      send_text(":\r\n");            // colon only, still a non-empty line
      send_text("a:b:c\n");          // second colon belongs to the value
      send_text("k\r\r\n");          // first CR becomes a name byte
      send_text("C\rD: \r\n");       // CR inside the name, value of spaces only
      send_byte(8'h00);
      send_byte(hrt_pkg::ChColon);
      send_byte(8'hFF);
      send_byte(hrt_pkg::ChLf);
   endtask

   task automatic test_line_limits();
      // only the low 13 bits count: limit 16, and a line of exactly 16 passes
      write_register(hrt_pkg::CsrMaxLine, 24'hFFE010);
      send_text("abcdefgh:ijklmno\r\n");
      write_register(hrt_pkg::CsrMaxLine, 24'h001FFF);
      send_text("Wide:");
      repeat (95) send_byte(line_byte());
      send_byte(hrt_pkg::ChLf);
      // a 200-byte line at a limit of 200, sent back to back
      write_register(hrt_pkg::CsrMaxLine, 24'd200);
      quiet = 1'b1;
      send_text("L:");
      repeat (198) send_byte(printable_byte());
      send_text("\r\n");
      quiet = 1'b0;
   endtask

   // Random header lines under a few limits; body_length rewritten with all-ones,
   // all-zeros and alternating patterns while it is not yet sampled.
   task automatic test_random_headers();
      logic [hrt_pkg::BodyLenBits-1:0] patterns[4];
      int                              target;
      logic [7:0]                      b;
      patterns = '{24'hFFFFFF, 24'h000000, 24'hAAAAAA, 24'h555555};
      for (int round = 0; round < 4; round++) begin
         // lines below hold at most 45 counted bytes
         write_register(hrt_pkg::CsrMaxLine, 24'($urandom_range(48, 300)));
         write_register(hrt_pkg::CsrBodyLen, patterns[round]);
         quiet  = (round == 1);
         target = bytes_sent + 100;
         while (bytes_sent < target) begin
            if ($urandom_range(0, 4) != 0) begin
               repeat ($urandom_range(1, 12))
                  send_byte(token_chars[$urandom_range(0, token_chars.len() - 1)]);
               send_byte(hrt_pkg::ChColon);
               repeat ($urandom_range(0, 2)) send_byte(hrt_pkg::ChSpace);
               repeat ($urandom_range(0, 30)) send_byte(line_byte());
            end else begin
               // noise line; a leading CR could make it blank and end the headers
               do b = line_byte(); while (b == hrt_pkg::ChCr);
               send_byte(b);
               repeat ($urandom_range(0, 39)) send_byte(line_byte());
            end
            if ($urandom_range(0, 1) == 1) send_byte(hrt_pkg::ChCr);
            send_byte(hrt_pkg::ChLf);
         end
         quiet = 1'b0;
      end
   endtask

   // Hold the receiver off while bytes keep coming, so the token queue fills and
   // req_tready drops.
   task automatic test_output_backpressure();
      write_register(hrt_pkg::CsrMaxLine, 24'd1024);
      hold_off_left = 300;
      quiet         = 1'b1;
      send_text("Pressure:");
      repeat (60) send_byte(printable_byte());
      send_text("\r\n");
      quiet = 1'b0;
   endtask

   // Finish the request: overlong header, empty body, or a real body.
   task automatic test_request_end();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         write_register(hrt_pkg::CsrMaxLine, 24'd16);
         send_text("Overflowing-Name: 12345");
         return;
      end
      if (pick < 4) write_register(hrt_pkg::CsrBodyLen, 24'd0);
      else if (pick == 4) write_register(hrt_pkg::CsrBodyLen, 24'($urandom_range(1, 2)));
      else write_register(hrt_pkg::CsrBodyLen, 24'($urandom_range(250, 450)));
      send_text("\r\n");
      if (parse_phase == hrt_pkg::PhBody) begin
         // the body in progress keeps the length sampled at the blank line
         write_register(hrt_pkg::CsrBodyLen, 24'($urandom_range(0, 24'hFFFFFF)));
         while (parse_phase == hrt_pkg::PhBody) send_byte(random_byte());
      end
   endtask

   // After done or error nothing may come out, whatever arrives.
   task automatic test_ignored_input();
      send_text("GET / x\r\n\r\n");
      repeat (40) send_byte(random_byte());
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      bit request_ok;
      int guard;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      csr_valid  <= 1'b0;
      csr_index  <= hrt_pkg::CsrMaxLine;
      csr_data   <= '0;
      reset_parse_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_register_setup();
      test_request_line(1'b1, request_ok);
      if (!request_ok) begin
         // the parser stays parked after the error; start a fresh request
         test_ignored_input();
         restart();
         test_request_line(1'b0, request_ok);
      end
      test_header_forms();
      test_line_limits();
      test_random_headers();
      test_output_backpressure();
      test_request_end();
      test_ignored_input();

      // drain what is still owed, with a bound
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_tokens.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         failure_count++;
         $error("%0d expected tokens never arrived", expected_tokens.size());
      end

      if (failure_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/hrt_pkg.sv
hdl/hrt_core.sv
hdl/hrt_rsp_fifo.sv
hdl/http_request_header_tokenizer.sv
tb/sv/testbench.sv
